FILE: rtl/gdo_pkg.sv
// Shared types, constants and calendar helper functions for the Gregorian date offset block.
package gdo_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    localparam logic [13:0] YEAR_MIN   = 14'd1582;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [21:0] SERIAL_LO  = 22'd577449;
    localparam logic [21:0] SERIAL_HI  = 22'd3652059;
    localparam logic [21:0] DAYS_400   = 22'd146097;
    localparam logic [21:0] DAYS_100   = 22'd36524;
    localparam logic [21:0] DAYS_4     = 22'd1461;
    localparam logic [21:0] DAYS_1     = 22'd365;
    // Reciprocal of 100 scaled by 2^19; exact floor for values below 16384.
    localparam logic [12:0] RECIP_100  = 13'd5243;

    typedef struct packed {
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [15:0] offset_days;
    } t_in;

    typedef struct packed {
        logic [13:0] new_year;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [2:0]  weekday;
        logic [8:0]  year_day;
        logic [21:0] serial_day;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLAMP,
        OP_MUL1,
        OP_MUL2,
        OP_SUM1,
        OP_SUM2,
        OP_SUM3,
        OP_SUM4,
        OP_PREP,
        OP_D400,
        OP_D100,
        OP_D4,
        OP_D1,
        OP_YEAR,
        OP_WALK,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic more;
        logic out_free;
    } t_stat;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        begin
            case (m)
                4'd2: n = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
                default: n = 5'd31;
            endcase
            return n;
        end
    endfunction

    // Days in the year before the first of month m (m is 1..12).
    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [8:0] s;
        begin
            case (m)
                4'd1:  s = 9'd0;
                4'd2:  s = 9'd31;
                4'd3:  s = 9'd59;
                4'd4:  s = 9'd90;
                4'd5:  s = 9'd120;
                4'd6:  s = 9'd151;
                4'd7:  s = 9'd181;
                4'd8:  s = 9'd212;
                4'd9:  s = 9'd243;
                4'd10: s = 9'd273;
                4'd11: s = 9'd304;
                default: s = 9'd334;
            endcase
            if (leap && m > 4'd2) begin
                s = s + 9'd1;
            end
            return s;
        end
    endfunction

    // Remainder by 7: since 8 is 1 mod 7, the octal digits are summed and folded.
    function automatic logic [2:0] mod7(input logic [21:0] v);
        logic [23:0] w;
        logic [5:0]  s;
        logic [3:0]  f;
        begin
            w = {2'b00, v};
            s = '0;
            for (int i = 0; i < 8; i++) begin
                s = s + 6'(w[3*i +: 3]);
            end
            f = 4'(s[5:3]) + 4'(s[2:0]);
            if (f >= 4'd7) begin
                f = f - 4'd7;
            end
            if (f == 4'd7) begin
                f = 4'd0;
            end
            return f[2:0];
        end
    endfunction

endpackage

FILE: rtl/gdo_ctrl.sv
// Sequencer that steps the date datapath through its phases, one command per cycle.
module gdo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  gdo_pkg::t_stat i_stat,
    output gdo_pkg::t_op  o_cmd,
    output logic          o_ready
);
    import gdo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_MUL1,
        S_MUL2,
        S_SUM1,
        S_SUM2,
        S_SUM3,
        S_SUM4,
        S_PREP,
        S_D400,
        S_D100,
        S_D4,
        S_D1,
        S_YEAR,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_op    r_cmd;
    logic   r_ready;

    function automatic t_op op_of(input t_state s);
        t_op o;
        begin
            case (s)
                S_CLAMP: o = OP_CLAMP;
                S_MUL1:  o = OP_MUL1;
                S_MUL2:  o = OP_MUL2;
                S_SUM1:  o = OP_SUM1;
                S_SUM2:  o = OP_SUM2;
                S_SUM3:  o = OP_SUM3;
                S_SUM4:  o = OP_SUM4;
                S_PREP:  o = OP_PREP;
                S_D400:  o = OP_D400;
                S_D100:  o = OP_D100;
                S_D4:    o = OP_D4;
                S_D1:    o = OP_D1;
                S_YEAR:  o = OP_YEAR;
                S_WALK:  o = OP_WALK;
                S_DONE:  o = OP_OUT;
                default: o = OP_NONE;
            endcase
            return o;
        end
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_accept) n_state = S_CLAMP;
            S_CLAMP: n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUM1;
            S_SUM1:  n_state = S_SUM2;
            S_SUM2:  n_state = S_SUM3;
            S_SUM3:  n_state = S_SUM4;
            S_SUM4:  n_state = S_PREP;
            S_PREP:  n_state = S_D400;
            S_D400:  if (!i_stat.more) n_state = S_D100;
            S_D100:  if (!i_stat.more) n_state = S_D4;
            S_D4:    if (!i_stat.more) n_state = S_D1;
            S_D1:    if (!i_stat.more) n_state = S_YEAR;
            S_YEAR:  n_state = S_WALK;
            S_WALK:  if (!i_stat.more) n_state = S_DONE;
            S_DONE:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // The command register always carries the operation of the state being entered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= OP_NONE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cmd   <= op_of(n_state);
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_cmd   = r_cmd;
    assign o_ready = r_ready;

endmodule

FILE: rtl/gdo_dp.sv
// Datapath: date clamping, serial day computation, calendar decomposition and output word.
module gdo_dp #(
    parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  gdo_pkg::t_in   i_in,
    input  gdo_pkg::t_op   i_cmd,
    output gdo_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gdo_pkg::t_out  o_out
);
    import gdo_pkg::*;

    localparam int RAW_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam int SUM_W = ((OFFSET_BITS > 22) ? OFFSET_BITS : 22) + 2;

    logic [13:0]                   r_y;
    logic [3:0]                    r_m;
    logic [4:0]                    r_d;
    logic signed [OFFSET_BITS-1:0] r_off;
    logic [13:0]                   r_p;
    logic [26:0]                   r_prod;
    logic [6:0]                    r_q100;
    logic [4:0]                    r_q400;
    logic                          r_cent;
    logic                          r_leap;
    logic [21:0]                   r_base;
    logic [21:0]                   r_rem;
    logic [2:0]                    r_week;
    logic [13:0]                   r_year;
    logic [1:0]                    r_c100;
    logic [4:0]                    r_c4;
    logic [1:0]                    r_c1;
    logic [8:0]                    r_yd;
    logic [8:0]                    r_wr;
    logic                          r_out_vld;
    t_out                          r_out;

    logic [RAW_W-1:0]       raw_off;
    logic [4:0]             dim;
    logic [4:0]             d_fix;
    logic signed [SUM_W-1:0] sum_s;
    logic [21:0]            s_clamp;
    logic                   more;
    logic                   out_free;

    assign raw_off  = RAW_W'(i_in.offset_days);
    assign dim      = month_days(r_m, r_leap);
    assign d_fix    = (r_d == 5'd0) ? 5'd1 : ((r_d > dim) ? dim : r_d);
    assign sum_s    = $signed(SUM_W'(r_base)) + SUM_W'(r_off);
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        if (sum_s < $signed(SUM_W'(SERIAL_LO))) begin
            s_clamp = SERIAL_LO;
        end else if (sum_s > $signed(SUM_W'(SERIAL_HI))) begin
            s_clamp = SERIAL_HI;
        end else begin
            s_clamp = sum_s[21:0];
        end
    end

    always_comb begin
        case (i_cmd)
            OP_D400: more = (r_rem >= DAYS_400);
            OP_D100: more = (r_rem >= DAYS_100) && (r_c100 != 2'd3);
            OP_D4:   more = (r_rem >= DAYS_4);
            OP_D1:   more = (r_rem >= DAYS_1) && (r_c1 != 2'd3);
            OP_WALK: more = (r_m < 4'd12) && (r_wr > 9'(dim));
            default: more = 1'b0;
        endcase
    end

    assign o_stat.more     = more;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_y   <= i_in.start_year;
            r_m   <= i_in.start_month;
            r_d   <= i_in.start_day;
            r_off <= raw_off[OFFSET_BITS-1:0];
        end
        case (i_cmd)
            OP_CLAMP: begin
                if (r_y < YEAR_MIN) begin
                    r_p <= YEAR_MIN - 14'd1;
                end else if (r_y > YEAR_MAX) begin
                    r_p <= YEAR_MAX - 14'd1;
                end else begin
                    r_p <= r_y - 14'd1;
                end
                if (r_m == 4'd0) begin
                    r_m <= 4'd1;
                end else if (r_m > 4'd12) begin
                    r_m <= 4'd12;
                end
            end
            OP_MUL1: begin
                r_prod <= 27'(r_p) * 27'(RECIP_100);
                r_base <= 22'(r_p) * 22'd365 + 22'(r_p[13:2]);
            end
            OP_MUL2: begin
                r_q100 <= r_prod[25:19];
                r_prod <= 27'(r_p[13:2]) * 27'(RECIP_100);
            end
            OP_SUM1: begin
                r_q400 <= r_prod[23:19];
                r_base <= r_base - 22'(r_q100);
                // The year itself is a century year when the previous year ends in 99.
                r_cent <= ((r_p - 14'(r_q100) * 14'd100) == 14'd99);
            end
            OP_SUM2: begin
                r_leap <= ((r_p[1:0] == 2'b11) && !r_cent) ||
                          ((r_p - 14'(r_q400) * 14'd400) == 14'd399);
                r_base <= r_base + 22'(r_q400);
            end
            OP_SUM3: begin
                r_base <= r_base + 22'(days_before(r_m, r_leap)) + 22'(d_fix);
            end
            OP_SUM4: begin
                r_base <= s_clamp;
            end
            OP_PREP: begin
                r_week <= mod7(r_base);
                r_rem  <= r_base - 22'd1;
                r_year <= 14'd1;
                r_c100 <= 2'd0;
                r_c4   <= 5'd0;
                r_c1   <= 2'd0;
            end
            OP_D400: begin
                if (more) begin
                    r_rem  <= r_rem - DAYS_400;
                    r_year <= r_year + 14'd400;
                end
            end
            OP_D100: begin
                if (more) begin
                    r_rem  <= r_rem - DAYS_100;
                    r_year <= r_year + 14'd100;
                    r_c100 <= r_c100 + 2'd1;
                end
            end
            OP_D4: begin
                if (more) begin
                    r_rem  <= r_rem - DAYS_4;
                    r_year <= r_year + 14'd4;
                    r_c4   <= r_c4 + 5'd1;
                end
            end
            OP_D1: begin
                if (more) begin
                    r_rem  <= r_rem - DAYS_1;
                    r_year <= r_year + 14'd1;
                    r_c1   <= r_c1 + 2'd1;
                end
            end
            OP_YEAR: begin
                r_yd   <= 9'(r_rem) + 9'd1;
                r_wr   <= 9'(r_rem) + 9'd1;
                r_m    <= 4'd1;
                // Last year of a four-year block is leap, except a century that is not the 400th.
                r_leap <= (r_c1 == 2'd3) && ((r_c4 != 5'd24) || (r_c100 == 2'd3));
            end
            OP_WALK: begin
                if (more) begin
                    r_wr <= r_wr - 9'(dim);
                    r_m  <= r_m + 4'd1;
                end
            end
            OP_OUT: begin
                if (out_free) begin
                    r_out.new_year   <= r_year;
                    r_out.new_month  <= r_m;
                    r_out.new_day    <= r_wr[4:0];
                    r_out.weekday    <= r_week;
                    r_out.year_day   <= r_yd;
                    r_out.serial_day <= r_base;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd == OP_OUT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

FILE: rtl/gregorian_date_offset.sv
// Top level of the Gregorian date offset block: sequencer plus datapath.
// Each word takes a start date and a signed day offset and returns the moved date, clamped to
// 1582-01-01 .. 9999-12-31, with its weekday, day of year and serial day. One word is worked at
// a time. Setup steps clamp the fields, multiply, sum up the serial day and prepare the split;
// then subtract loops run over 400-year, 100-year, 4-year and 1-year spans, a step starts the
// month walk, the month walk runs and a last step moves the result into the output register,
// where the sequencer waits while that register still holds a result the receiver has not taken.
// The result sits in an output register, so a new word is taken as soon as the previous one has
// been moved there.
module gregorian_date_offset #(
    parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gdo_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gdo_pkg::t_out o_out
);
    import gdo_pkg::*;

    t_op   cmd;
    t_stat stat;
    logic  ready;
    logic  accept;

    assign accept     = i_in_valid && ready;
    assign o_in_ready = ready;

    gdo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (ready)
    );

    gdo_dp #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule

FILE: tb/sv/date_offset_checker.sv
// Checker for the date offset block: predicts each moved date and compares it with the output.
module date_offset_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  gdo_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  gdo_pkg::t_out i_out,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_checked
);
    import gdo_pkg::*;

    localparam int ERA_DAYS     = 146097;
    localparam int CENTURY_DAYS = 36524;
    localparam int QUAD_DAYS    = 1461;
    localparam int YEAR_DAYS    = 365;

    t_out expected_dates[$];
    int   mismatches;
    int   compared;

    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(input int y, input int m);
        int n;
        case (m)
            2: n = is_leap(y) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default: n = 31;
        endcase
        return n;
    endfunction

    // Day 1 is 0001-01-01.
    function automatic int day_number(input int y, input int m, input int d);
        int p;
        int s;
        p = y - 1;
        s = p * 365 + p / 4 - p / 100 + p / 400 + d;
        for (int j = 1; j < m; j++) begin
            s += month_length(y, j);
        end
        return s;
    endfunction

    function automatic t_out moved_date(input t_in w);
        t_out res;
        int   y;
        int   m;
        int   d;
        int   off;
        int   s;
        int   lo;
        int   hi;
        int   r;
        int   q400;
        int   q100;
        int   q4;
        int   q1;
        int   yd;
        y   = int'(w.start_year);
        m   = int'(w.start_month);
        d   = int'(w.start_day);
        // The block runs with the default offset width, which is the whole field.
        off = int'($signed(w.offset_days));
        if (y < int'(YEAR_MIN)) begin
            y = int'(YEAR_MIN);
        end
        if (y > int'(YEAR_MAX)) begin
            y = int'(YEAR_MAX);
        end
        if (m < 1) begin
            m = 1;
        end
        if (m > 12) begin
            m = 12;
        end
        if (d < 1) begin
            d = 1;
        end
        if (d > month_length(y, m)) begin
            d = month_length(y, m);
        end
        lo = day_number(int'(YEAR_MIN), 1, 1);
        hi = day_number(int'(YEAR_MAX), 12, 31);
        s  = day_number(y, m, d) + off;
        if (s < lo) begin
            s = lo;
        end
        if (s > hi) begin
            s = hi;
        end
        // Split the day count into 400, 100, 4 and 1 year spans; the last century of an era
        // and the last year of a quad are one day longer, hence the caps at 3.
        r    = s - 1;
        q400 = r / ERA_DAYS;
        r    = r % ERA_DAYS;
        q100 = r / CENTURY_DAYS;
        if (q100 == 4) begin
            q100 = 3;
        end
        r   -= q100 * CENTURY_DAYS;
        q4   = r / QUAD_DAYS;
        r    = r % QUAD_DAYS;
        q1   = r / YEAR_DAYS;
        if (q1 == 4) begin
            q1 = 3;
        end
        r  -= q1 * YEAR_DAYS;
        y   = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
        yd  = r + 1;
        m   = 1;
        r   = yd;
        while (m < 12 && r > month_length(y, m)) begin
            r -= month_length(y, m);
            m++;
        end
        res.new_year   = 14'(y);
        res.new_month  = 4'(m);
        res.new_day    = 5'(r);
        res.weekday    = 3'(s % 7);
        res.year_day   = 9'(yd);
        res.serial_day = 22'(s);
        return res;
    endfunction

    task automatic check_field(input string label, input logic [21:0] want,
                               input logic [21:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            expected_dates.delete();
            mismatches   = 0;
            compared     = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
            o_checked    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_dates.size() == 0) begin
                    $display("%0t: result word with no date expected, got %p", $time, i_out);
                    mismatches++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("new_year", 22'(want.new_year), 22'(i_out.new_year));
                    check_field("new_month", 22'(want.new_month), 22'(i_out.new_month));
                    check_field("new_day", 22'(want.new_day), 22'(i_out.new_day));
                    check_field("weekday", 22'(want.weekday), 22'(i_out.weekday));
                    check_field("year_day", 22'(want.year_day), 22'(i_out.year_day));
                    check_field("serial_day", want.serial_day, i_out.serial_day);
                    compared++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_dates.push_back(moved_date(i_in));
            end
            o_fail_count <= mismatches;
            o_pending    <= expected_dates.size();
            o_checked    <= compared;
        end
    end

endmodule

FILE: tb/sv/tb_gregorian_date_offset.sv
// Testbench top for the date offset block: clock, reset, stimulus, pacing and verdict.
module tb_gregorian_date_offset;
    import gdo_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 310;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_word;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int words_sent = 0;
    int send_idle_pct = 31;
    int recv_idle_pct = 78;

    gregorian_date_offset i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word)
    );

    date_offset_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int last_day(input int y, input int m);
        int n;
        case (m)
            2: n = (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default: n = 31;
        endcase
        return n;
    endfunction

    function automatic t_in make_word(input int y, input int m, input int d, input int off);
        t_in w;
        w.start_year  = 14'(y);
        w.start_month = 4'(m);
        w.start_day   = 5'(d);
        w.offset_days = 16'(off);
        return w;
    endfunction

    function automatic t_in random_word();
        t_in w;
        int  sel;
        int  y;
        int  m;
        int  d;
        int  off;
        sel = $urandom_range(99);
        if (sel < 8) begin
            // Raw fields, including years, months and days the block must clamp.
            w.start_year  = 14'($urandom);
            w.start_month = 4'($urandom);
            w.start_day   = 5'($urandom);
            w.offset_days = 16'($urandom);
            return w;
        end
        if (sel < 16) begin
            y = $urandom_range(1582, 1620);
        end else if (sel < 24) begin
            y = $urandom_range(9950, 9999);
        end else begin
            y = $urandom_range(1582, 9999);
        end
        m = $urandom_range(1, 12);
        d = ($urandom_range(3) == 0) ? last_day(y, m) : $urandom_range(1, last_day(y, m));
        case ($urandom_range(9))
            0, 1, 2, 3: off = int'($signed(16'($urandom)));
            4, 5: off = $urandom_range(64) - 32;
            6: off = ($urandom_range(1) ? 1 : -1) * $urandom_range(365, 1500);
            7: off = $urandom_range(1) ? 32767 : -32768;
            default: off = $urandom_range(6000) - 3000;
        endcase
        return make_word(y, m, d, off);
    endfunction

    // Holds the word on the channel until it is taken; a random gap comes first.
    task automatic send_word(input t_in w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do begin
            @(posedge i_clk);
        end while (!in_ready);
        words_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Calendar corners and clamping cases.
        send_word(make_word(1582, 1, 1, -32768));
        send_word(make_word(1582, 1, 1, 0));
        send_word(make_word(9999, 12, 31, 32767));
        send_word(make_word(9999, 12, 31, 0));
        send_word(make_word(0, 0, 0, 0));
        send_word(make_word(16383, 15, 31, -1));
        send_word(make_word(1581, 6, 15, 100));
        send_word(make_word(2000, 2, 29, 1));
        send_word(make_word(1900, 2, 29, 0));
        send_word(make_word(2100, 3, 1, -1));
        send_word(make_word(2004, 2, 28, 1));
        send_word(make_word(2020, 1, 1, -1));
        send_word(make_word(2019, 12, 31, 1));
        send_word(make_word(2024, 2, 31, 0));
        send_word(make_word(1600, 2, 29, 32767));
        send_word(make_word(1700, 12, 31, 1));
        send_word(make_word(2023, 4, 30, -32768));
        send_word(make_word(5000, 6, 15, 32767));
        send_word(make_word(1583, 1, 1, -366));
        send_word(make_word(9998, 12, 31, 366));
        send_word(make_word(1999, 12, 31, 0));
        send_word(make_word(2001, 3, 1, -1));
        send_word(make_word(2000, 12, 31, 0));
        send_word(make_word(1582, 12, 31, -364));
        drain_results();

        repeat (RANDOM_WORDS) send_word(random_word());
        drain_results();

        send_idle_pct = 78;
        recv_idle_pct = 31;
        repeat (RANDOM_WORDS) send_word(random_word());
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_WORDS) send_word(random_word());
        drain_results();
        repeat (100) @(posedge i_clk);

        $display("Sent %0d start dates and offsets under three pacing mixes, %0d results checked.",
                 words_sent, checked);
        $display("Covered clamped fields, leap rules, floor and ceiling saturation.");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gdo_pkg.sv
rtl/gdo_ctrl.sv
rtl/gdo_dp.sv
rtl/gregorian_date_offset.sv
tb/sv/date_offset_checker.sv
tb/sv/tb_gregorian_date_offset.sv
